@@ hw/rtl/lzssd_pkg.sv @@
// shared types and constants for the lzss window decompressor
package lzssd_pkg;

  // width of the match position field in the two match bytes
  localparam int unsigned POS_W = 12;

  // parse phase codes
  localparam logic [1:0] PHASE_FLAG   = 2'd0;
  localparam logic [1:0] PHASE_TOKEN  = 2'd1;
  localparam logic [1:0] PHASE_SECOND = 2'd2;

  // tokens announced by one flag byte
  localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;

  // match length is the low nibble plus this bias
  localparam logic [4:0] LEN_BIAS = 5'd2;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PARSE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;     // take the input byte, clear on start of stream
    logic load_flag;   // byte is a flag byte
    logic load_high;   // byte is the first match byte
    logic literal;     // store and emit the byte as a literal
    logic emit_end;    // emit the end marker
    logic start_copy;  // load source position and length
    logic read;        // read the window at the source position
    logic copy;        // emit and store the byte just read
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       stream_done;
    logic [1:0] phase;
    logic       flag_lit;
    logic       pos_zero;
    logic       out_free;
    logic       last_copy;
  } status_t;

endpackage

@@ hw/rtl/lzssd_in_if.sv @@
// input channel: one compressed byte per transfer
interface lzssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_stream;

  modport source (output valid, output in_byte, output start_of_stream, input ready);
  modport sink (input valid, input in_byte, input start_of_stream, output ready);
endinterface

@@ hw/rtl/lzssd_out_if.sv @@
// output channel: one decompressed byte or end marker per transfer
interface lzssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_stream;

  modport source (output valid, output out_byte, output last_of_run, output end_of_stream,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input end_of_stream,
                output ready);
endinterface

@@ hw/rtl/lzss_window_decompressor.sv @@
// lzss decompressor: flag, literal and match bytes in, decompressed bytes out
// each input byte is captured while idle and then parsed; a literal or end marker waits for the output register
// a match of length n does, for each byte, one window read then one write and emit
// a new input byte is taken only once the previous byte is parsed and any match copy is done
// reset: parse state cleared, write pointer to one; the window is not swept, a fill count
// makes entries not written since reset or start of stream read as zero
module lzss_window_decompressor #(
  parameter int unsigned WINDOW_SIZE = 4096
) (
  input logic         clk,
  input logic         rst,
  lzssd_in_if.sink    stream,
  lzssd_out_if.source result
);

  lzssd_pkg::cmd_t    cmd;
  lzssd_pkg::status_t status;

  // controller
  lzssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (stream.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  lzssd_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .in_byte         (stream.in_byte),
    .start_of_stream (stream.start_of_stream),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (result.ready),
    .out_valid       (result.valid),
    .out_byte        (result.out_byte),
    .last_of_run     (result.last_of_run),
    .end_of_stream   (result.end_of_stream)
  );

endmodule

@@ hw/rtl/lzssd_ctrl.sv @@
// controller state machine: sequences parsing and match copies
module lzssd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzssd_pkg::status_t status,
  output lzssd_pkg::cmd_t    cmd
);

  lzssd_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzssd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == lzssd_pkg::ST_IDLE);
    case (state)
      lzssd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = lzssd_pkg::ST_PARSE;
        end
      end
      lzssd_pkg::ST_PARSE: begin
        if (status.stream_done) begin
          state_next = lzssd_pkg::ST_IDLE;
        end else begin
          case (status.phase)
            lzssd_pkg::PHASE_TOKEN: begin
              if (status.flag_lit) begin
                // literal waits for the output register
                if (status.out_free) begin
                  cmd.literal = 1'b1;
                  state_next  = lzssd_pkg::ST_IDLE;
                end
              end else begin
                cmd.load_high = 1'b1;
                state_next    = lzssd_pkg::ST_IDLE;
              end
            end
            lzssd_pkg::PHASE_SECOND: begin
              if (status.pos_zero) begin
                if (status.out_free) begin
                  cmd.emit_end = 1'b1;
                  state_next   = lzssd_pkg::ST_IDLE;
                end
              end else begin
                cmd.start_copy = 1'b1;
                state_next     = lzssd_pkg::ST_READ;
              end
            end
            default: begin
              cmd.load_flag = 1'b1;
              state_next    = lzssd_pkg::ST_IDLE;
            end
          endcase
        end
      end
      lzssd_pkg::ST_READ: begin
        cmd.read   = 1'b1;
        state_next = lzssd_pkg::ST_EMIT;
      end
      lzssd_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.copy   = 1'b1;
          state_next = status.last_copy ? lzssd_pkg::ST_IDLE : lzssd_pkg::ST_READ;
        end
      end
      default: begin
        state_next = lzssd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/lzssd_datapath.sv @@
// datapath: parse registers, dictionary memory and output register
module lzssd_datapath #(
  parameter int unsigned WINDOW_SIZE = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         in_byte,
  input  logic               start_of_stream,
  input  lzssd_pkg::cmd_t    cmd,
  output lzssd_pkg::status_t status,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               last_of_run,
  output logic               end_of_stream
);

  localparam int unsigned AW = $clog2(WINDOW_SIZE);

  logic [7:0]    mem [WINDOW_SIZE];
  logic [7:0]    byte_reg;
  logic [7:0]    pending_high;
  logic [7:0]    flag_bits;
  logic [3:0]    tokens_left;
  logic [1:0]    phase;
  logic          stream_done;
  logic [AW-1:0] write_position;
  logic [AW:0]   fill;
  logic [AW-1:0] src;
  logic [4:0]    copy_left;
  logic [7:0]    rd_data;
  logic          rd_valid;

  logic [lzssd_pkg::POS_W-1:0] pos;
  logic [3:0]    tokens_dec;
  logic [7:0]    copy_byte;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic [AW-1:0] src_offset;

  // decode helpers
  assign pos        = {pending_high, byte_reg[7:4]};
  assign tokens_dec = tokens_left - 4'd1;
  assign copy_byte  = rd_valid ? rd_data : 8'd0;
  assign wr_en      = cmd.literal | cmd.copy;
  assign wr_data    = cmd.literal ? byte_reg : copy_byte;
  assign src_offset = src - AW'(1);

  // status to controller
  assign status.stream_done = stream_done;
  assign status.phase       = phase;
  assign status.flag_lit    = flag_bits[0];
  assign status.pos_zero    = (pos[AW-1:0] == '0);
  assign status.out_free    = !out_valid || out_ready;
  assign status.last_copy   = (copy_left == 5'd1);

  // parse state, write pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high   <= 8'd0;
      flag_bits      <= 8'd0;
      tokens_left    <= 4'd0;
      phase          <= lzssd_pkg::PHASE_FLAG;
      stream_done    <= 1'b0;
      write_position <= AW'(1);
      fill           <= '0;
    end else begin
      if (cmd.capture && start_of_stream) begin
        pending_high   <= 8'd0;
        flag_bits      <= 8'd0;
        tokens_left    <= 4'd0;
        phase          <= lzssd_pkg::PHASE_FLAG;
        stream_done    <= 1'b0;
        write_position <= AW'(1);
        fill           <= '0;
      end
      if (cmd.load_flag) begin
        flag_bits   <= byte_reg;
        tokens_left <= lzssd_pkg::TOKENS_PER_FLAG;
        phase       <= lzssd_pkg::PHASE_TOKEN;
      end
      if (cmd.load_high) begin
        pending_high <= byte_reg;
        phase        <= lzssd_pkg::PHASE_SECOND;
      end
      if (cmd.emit_end) begin
        stream_done <= 1'b1;
      end
      // token finished: literal, or last byte of a copy
      if (cmd.literal || (cmd.copy && copy_left == 5'd1)) begin
        flag_bits   <= {1'b0, flag_bits[7:1]};
        tokens_left <= tokens_dec;
        phase       <= (tokens_dec == 4'd0) ? lzssd_pkg::PHASE_FLAG : lzssd_pkg::PHASE_TOKEN;
      end
      if (wr_en) begin
        write_position <= write_position + AW'(1);
        if (!fill[AW]) begin
          fill <= fill + (AW+1)'(1);
        end
      end
    end
  end

  // input byte and copy counters
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_reg <= in_byte;
    end
    if (cmd.start_copy) begin
      src       <= pos[AW-1:0];
      copy_left <= 5'(byte_reg[3:0]) + lzssd_pkg::LEN_BIAS;
    end else if (cmd.copy) begin
      src       <= src + AW'(1);
      copy_left <= copy_left - 5'd1;
    end
  end

  // dictionary memory, entries are written in order from position one
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_position] <= wr_data;
    end
    if (cmd.read) begin
      rd_data <= mem[src];
    end
  end

  // an entry not yet written since the clear reads as zero
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_valid <= fill[AW] || ({1'b0, src_offset} < fill);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.literal || cmd.emit_end || cmd.copy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.literal) begin
      out_byte      <= byte_reg;
      last_of_run   <= 1'b1;
      end_of_stream <= 1'b0;
    end else if (cmd.emit_end) begin
      out_byte      <= 8'd0;
      last_of_run   <= 1'b1;
      end_of_stream <= 1'b1;
    end else if (cmd.copy) begin
      out_byte      <= copy_byte;
      last_of_run   <= (copy_left == 5'd1);
      end_of_stream <= 1'b0;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the lzss window decompressor: directed and random streams, checked on the fly
`timescale 1ns / 1ps

module tb_top;

  localparam int WIN_BYTES = 4096;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       sos;
  } comp_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eos;
  } plain_byte_t;

  logic clk;
  logic rst;

  lzssd_in_if  stream_if ();
  lzssd_out_if result_if ();

  lzss_window_decompressor DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  // compressed bytes waiting to be sent, decompressed bytes waiting to arrive
  comp_byte_t  comp_bytes[$];
  plain_byte_t expected_plain[$];
  comp_byte_t  next_byte;
  plain_byte_t want;

  int pushed_count = 0;
  int accepted_count = 0;
  int err_count = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic in_taken = 1'b0;

  // stimulus-side guess of the write pointer, only used to aim matches
  logic [11:0] gen_wp = 12'd1;

  // decoder state mirrored by the testbench
  logic [7:0]                  dict [0:WIN_BYTES-1];
  logic [lzssd_pkg::POS_W-1:0] wr_pos;
  logic [7:0]                  flag_reg;
  logic [3:0]                  tok_left;
  logic [1:0]                  phase;
  logic [7:0]                  high_byte;
  logic                        done;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_decoder();
    for (int i = 0; i < WIN_BYTES; i++) dict[i] = 8'h00;
    wr_pos = 12'd1;
    flag_reg = 8'h00;
    tok_left = 4'd0;
    phase = lzssd_pkg::PHASE_FLAG;
    high_byte = 8'h00;
    done = 1'b0;
  endfunction

  function automatic void dict_write(input logic [7:0] b);
    dict[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
  endfunction

  function automatic void queue_plain(input logic [7:0] b, input logic last, input logic eos);
    plain_byte_t r;
    r.data = b;
    r.last = last;
    r.eos = eos;
    expected_plain.insert(expected_plain.size(), r);
  endfunction

  function automatic void advance_token();
    flag_reg = flag_reg >> 1;
    tok_left = tok_left - 1'b1;
    phase = (tok_left == 4'd0) ? lzssd_pkg::PHASE_FLAG : lzssd_pkg::PHASE_TOKEN;
  endfunction

  // work out the decompressed bytes caused by one compressed byte
  function automatic void decode_byte(input logic [7:0] b, input logic sos);
    logic [lzssd_pkg::POS_W-1:0] src;
    logic [4:0]                  len;
    logic [7:0]                  d;
    if (sos) clear_decoder();
    if (done) return;
    case (phase)
      lzssd_pkg::PHASE_TOKEN: begin
        if (flag_reg[0]) begin
          dict_write(b);
          queue_plain(b, 1'b1, 1'b0);
          advance_token();
        end else begin
          high_byte = b;
          phase = lzssd_pkg::PHASE_SECOND;
        end
      end
      lzssd_pkg::PHASE_SECOND: begin
        src = {high_byte, b[7:4]};
        if (src == '0) begin
          done = 1'b1;
          queue_plain(8'h00, 1'b1, 1'b1);
        end else begin
          len = {1'b0, b[3:0]} + lzssd_pkg::LEN_BIAS;
          // copy one byte at a time so overlapping copies repeat data
          for (int i = 0; i < len; i++) begin
            d = dict[src];
            dict_write(d);
            src = src + 1'b1;
            queue_plain(d, (i == len - 1), 1'b0);
          end
          advance_token();
        end
      end
      default: begin
        flag_reg = b;
        tok_left = lzssd_pkg::TOKENS_PER_FLAG;
        phase = lzssd_pkg::PHASE_TOKEN;
      end
    endcase
  endfunction

  task automatic push_item(input logic [7:0] b, input logic sos);
    comp_byte_t c;
    c.data = b;
    c.sos = sos;
    comp_bytes.insert(comp_bytes.size(), c);
    pushed_count++;
  endtask

  // one stream from a start of stream: random flags, literals and matches
  task automatic add_stream(input int item_budget, input int byte_budget, input int literal_pct,
                            input int min_nib, input bit finish_it);
    int base;
    int n_bytes;
    int k;
    int r;
    bit first;
    logic [7:0]  flags;
    logic [11:0] pos;
    logic [3:0]  nib;
    base = pushed_count;
    n_bytes = 0;
    k = 8;
    flags = 8'h00;
    first = 1'b1;
    gen_wp = 12'd1;
    while (!((pushed_count - base >= item_budget) ||
             (byte_budget != 0 && n_bytes >= byte_budget))) begin
      if (k == 8) begin
        for (int j = 0; j < 8; j++) flags[j] = ($urandom_range(99) < literal_pct);
        push_item(flags, first);
        first = 1'b0;
        k = 0;
      end else begin
        if (flags[k]) begin
          push_item(8'($urandom), 1'b0);
          gen_wp++;
          n_bytes++;
        end else begin
          // mostly close behind the write pointer, some anywhere, some near the top
          r = $urandom_range(19);
          if (r < 3) pos = 12'($urandom_range(4095, 4080));
          else if (r < 8) pos = 12'($urandom_range(4095, 1));
          else pos = gen_wp - 12'($urandom_range(40, 1));
          if (pos == 12'h000) pos = 12'hFFF;
          nib = 4'($urandom_range(15, min_nib));
          push_item(pos[11:4], 1'b0);
          // sometimes leave a match cut after its first byte
          if ((pushed_count - base >= item_budget) && $urandom_range(3) == 0) return;
          push_item({pos[3:0], nib}, 1'b0);
          gen_wp = gen_wp + 12'(nib + 2);
          n_bytes = n_bytes + nib + 2;
        end
        k++;
      end
    end
    if (finish_it) begin
      // run out the literals up to the next match slot, then the end marker
      while (k < 8 && flags[k]) begin
        push_item(8'($urandom), 1'b0);
        k++;
      end
      if (k == 8) push_item(8'($urandom) & 8'hFE, 1'b0);
      push_item(8'h00, 1'b0);
      push_item({4'h0, 4'($urandom)}, 1'b0);
      // trailing bytes after the end are ignored
      repeat ($urandom_range(3)) push_item(8'($urandom), 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (accepted_count != pushed_count || expected_plain.size() != 0) @(negedge clk);
  endtask

  // input driver and result ready, changed on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      stream_if.valid <= 1'b0;
      result_if.ready <= 1'b0;
    end else begin
      if (!stream_if.valid || in_taken) begin
        if (comp_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = comp_bytes.pop_front();
          stream_if.valid <= 1'b1;
          stream_if.in_byte <= next_byte.data;
          stream_if.start_of_stream <= next_byte.sos;
        end else begin
          stream_if.valid <= 1'b0;
        end
      end
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // predict on every input transfer, check every output transfer
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= stream_if.valid && stream_if.ready;
      if (stream_if.valid && stream_if.ready) begin
        accepted_count++;
        decode_byte(stream_if.in_byte, stream_if.start_of_stream);
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_plain.size() == 0) begin
          $display("%0t: unexpected result: out_byte %0h last_of_run %0b end_of_stream %0b",
                   $time, result_if.out_byte, result_if.last_of_run, result_if.end_of_stream);
          err_count++;
        end else begin
          want = expected_plain.pop_front();
          if (result_if.out_byte !== want.data) begin
            $display("%0t: out_byte expected %0h actual %0h", $time, want.data,
                     result_if.out_byte);
            err_count++;
          end
          if (result_if.last_of_run !== want.last) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time, want.last,
                     result_if.last_of_run);
            err_count++;
          end
          if (result_if.end_of_stream !== want.eos) begin
            $display("%0t: end_of_stream expected %0b actual %0b", $time, want.eos,
                     result_if.end_of_stream);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", stall_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : run
    int mark;
    clk = 1'b0;
    rst = 1'b1;
    stream_if.valid = 1'b0;
    stream_if.in_byte = 8'h00;
    stream_if.start_of_stream = 1'b0;
    result_if.ready = 1'b0;
    clear_decoder();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 78;

    // first flag right after reset, no start of stream; literal 0, overlapping
    // match from position 1, literal ff, match of two from the top wrapping to 0
    push_item(8'hF5, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h1F, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hF0, 1'b0);
    push_item(8'hA5, 1'b0);
    push_item(8'h5A, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h7F, 1'b0);
    // all-match flag, one match then the end marker, then ignored bytes
    push_item(8'h00, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h23, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h0A, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    // restart, then restart again in the middle of a match
    push_item(8'h01, 1'b1);
    push_item(8'h3C, 1'b0);
    push_item(8'h12, 1'b0);
    push_item(8'hFF, 1'b1);
    push_item(8'h81, 1'b0);
    wait_drained();

    mark = pushed_count;
    while (pushed_count - mark < 90)
      add_stream($urandom_range(50, 8), 0, 45, 0, 1'($urandom_range(1)));
    repeat (12) push_item(8'($urandom), $urandom_range(7) == 0);
    wait_drained();

    send_idle_pct = 78;
    recv_idle_pct = 34;
    mark = pushed_count;
    while (pushed_count - mark < 90)
      add_stream($urandom_range(50, 8), 0, 45, 0, 1'($urandom_range(1)));
    repeat (12) push_item(8'($urandom), $urandom_range(7) == 0);
    wait_drained();

    // long matches that fill a good part of the window
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_stream(100000, 1000, 5, 12, 1'b1);
    repeat (12) push_item(8'($urandom), $urandom_range(7) == 0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0 && expected_plain.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
